// ----- rtl/height_color_map_tokenizer_unit_defines.svh -----
// Assertion macros shared by the height color map tokenizer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef HEIGHT_COLOR_MAP_TOKENIZER_UNIT_DEFINES_SVH
`define HEIGHT_COLOR_MAP_TOKENIZER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hcmt_pkg.sv -----
// Types, character codes and helper functions of the height color map tokenizer.
// Depends on nothing; used by hcmt_core, hcmt_out_fifo and the top level of the block.
package hcmt_pkg;

   // Character codes.
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Register indexes and reset values.
   localparam logic [1:0] CSR_ROW_WIDTH     = 2'd0;
   localparam logic [1:0] CSR_ROW_COUNT     = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_COLOR = 2'd2;
   localparam logic [10:0] ROW_WIDTH_RESET     = 11'd1024;
   localparam logic [10:0] ROW_COUNT_RESET     = 11'd1024;
   localparam logic [23:0] DEFAULT_COLOR_RESET = 24'hFFFFFF;

   // Result kinds and error codes.
   localparam logic       KIND_POINT     = 1'b0;
   localparam logic       KIND_STATUS    = 1'b1;
   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_TOO_MANY   = 2'd1;
   localparam logic [1:0] ERR_TOO_FEW    = 2'd2;

   // Output queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEIGHT = 3'd1,
      PH_SKIP   = 3'd3,
      PH_COMMA  = 3'd4,
      PH_ZERO   = 3'd5,
      PH_HEX    = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic               kind;
      logic [9:0]         column;
      logic [9:0]         row;
      logic signed [31:0] height;
      logic [31:0]        color;
      logic [1:0]         error;
      logic               last;
   } result_type;

   typedef struct packed {
      logic       valid_a;
      logic       valid_b;
      result_type data_a;
      result_type data_b;
   } push_type;

   typedef struct packed {
      logic halted;
      logic row_open;
   } core_status_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  has_room;
   } fifo_status_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   // Returns {valid, nibble} for a hex digit of either case.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (is_digit(b)) begin
         r = {1'b1, b[3:0]};
      end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
         r = {1'b1, 4'(b[3:0] + 4'd9)};
      end
      return r;
   endfunction

endpackage

// ----- rtl/hcmt_if.sv -----
// Stream interfaces of the height color map tokenizer: text words in, result words out.
// Depends on nothing.
interface hcmt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_file;

   modport source (output valid, output text_byte, output end_of_file, input ready);
   modport sink (input valid, input text_byte, input end_of_file, output ready);
endinterface

interface hcmt_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [9:0]         column;
   logic [9:0]         row;
   logic signed [31:0] height;
   logic [31:0]        color;
   logic [1:0]         error;
   logic               last;

   modport source (output valid, output kind, output column, output row, output height,
                   output color, output error, output last, input ready);
   modport sink (input valid, input kind, input column, input row, input height,
                 input color, input error, input last, output ready);
endinterface

// ----- rtl/hcmt_core.sv -----
// Tokenizer state, configuration registers and per-word result generation.
// Depends on hcmt_pkg.
module hcmt_core #(
   parameter int MAX_DIM = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 text_byte,
   input  logic                       end_of_file,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [23:0]                csr_write_data,
   output hcmt_pkg::push_type         push,
   output hcmt_pkg::core_status_type  status
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
   localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

   logic [10:0] row_width_ff, row_count_ff;
   logic [23:0] default_color_ff;

   hcmt_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [CNT_W-1:0] row_index_ff, row_index_in;
   logic [31:0] height_acc_ff, height_acc_in;
   logic [31:0] color_acc_ff, color_acc_in;
   logic negative_ff, negative_in;
   logic has_color_ff, has_color_in;
   logic row_open_ff, row_open_in;
   logic halted_ff, halted_in;

   logic [CMP_W-1:0] width_lim, count_lim, col_ext, row_ext;
   logic [CMP_W:0]   lines;
   logic [4:0]       hv;
   logic             do_clear;
   hcmt_pkg::result_type point_res, status_res;

   assign width_lim = (CMP_W'(row_width_ff) > DIM_LIMIT) ? DIM_LIMIT : CMP_W'(row_width_ff);
   assign count_lim = (CMP_W'(row_count_ff) > DIM_LIMIT) ? DIM_LIMIT : CMP_W'(row_count_ff);
   assign hv = hcmt_pkg::hex_value(text_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= hcmt_pkg::ROW_WIDTH_RESET;
         row_count_ff     <= hcmt_pkg::ROW_COUNT_RESET;
         default_color_ff <= hcmt_pkg::DEFAULT_COLOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hcmt_pkg::CSR_ROW_WIDTH:     row_width_ff     <= csr_write_data[10:0];
            hcmt_pkg::CSR_ROW_COUNT:     row_count_ff     <= csr_write_data[10:0];
            hcmt_pkg::CSR_DEFAULT_COLOR: default_color_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hcmt_pkg::PH_IDLE;
         column_count_ff <= '0;
         row_index_ff    <= '0;
         height_acc_ff   <= '0;
         color_acc_ff    <= '0;
         negative_ff     <= 1'b0;
         has_color_ff    <= 1'b0;
         row_open_ff     <= 1'b0;
         halted_ff       <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         column_count_ff <= column_count_in;
         row_index_ff    <= row_index_in;
         height_acc_ff   <= height_acc_in;
         color_acc_ff    <= color_acc_in;
         negative_ff     <= negative_in;
         has_color_ff    <= has_color_in;
         row_open_ff     <= row_open_in;
         halted_ff       <= halted_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      column_count_in = column_count_ff;
      row_index_in    = row_index_ff;
      height_acc_in   = height_acc_ff;
      color_acc_in    = color_acc_ff;
      negative_in     = negative_ff;
      has_color_in    = has_color_ff;
      row_open_in     = row_open_ff;
      halted_in       = halted_ff;
      do_clear        = 1'b0;
      push            = '0;
      col_ext         = CMP_W'(column_count_ff);
      row_ext         = CMP_W'(row_index_ff);
      lines           = '0;
      point_res       = '0;
      status_res      = '0;
      status_res.kind = hcmt_pkg::KIND_STATUS;
      status_res.last = 1'b1;

      if (accept) begin
         if (halted_ff) begin
            do_clear = end_of_file;
         end else if (!row_open_ff && (row_ext >= count_lim)) begin
            // A new line would open past the configured row count.
            status_res.error = hcmt_pkg::ERR_TOO_MANY;
            push.valid_a     = 1'b1;
            push.data_a      = status_res;
            halted_in        = 1'b1;
            do_clear         = end_of_file;
         end else begin
            row_open_in = 1'b1;
            if (!hcmt_pkg::is_space(text_byte)) begin
               unique case (phase_ff)
                  hcmt_pkg::PH_IDLE: begin
                     height_acc_in = '0;
                     color_acc_in  = '0;
                     has_color_in  = 1'b0;
                     negative_in   = (text_byte == hcmt_pkg::CHAR_MINUS);
                     if ((text_byte == hcmt_pkg::CHAR_MINUS)
                         || (text_byte == hcmt_pkg::CHAR_PLUS)) begin
                        phase_in = hcmt_pkg::PH_HEIGHT;
                     end else if (hcmt_pkg::is_digit(text_byte)) begin
                        height_acc_in = {28'd0, text_byte[3:0]};
                        phase_in      = hcmt_pkg::PH_HEIGHT;
                     end else if (text_byte == hcmt_pkg::CHAR_COMMA) begin
                        phase_in = hcmt_pkg::PH_COMMA;
                     end else begin
                        phase_in = hcmt_pkg::PH_SKIP;
                     end
                  end
                  hcmt_pkg::PH_HEIGHT: begin
                     if (hcmt_pkg::is_digit(text_byte)) begin
                        // Times ten as two shifts and an add.
                        height_acc_in = (height_acc_ff << 3) + (height_acc_ff << 1)
                                        + {28'd0, text_byte[3:0]};
                     end else if (text_byte == hcmt_pkg::CHAR_COMMA) begin
                        phase_in = hcmt_pkg::PH_COMMA;
                     end else begin
                        phase_in = hcmt_pkg::PH_SKIP;
                     end
                  end
                  hcmt_pkg::PH_SKIP: begin
                     if (text_byte == hcmt_pkg::CHAR_COMMA) begin
                        phase_in = hcmt_pkg::PH_COMMA;
                     end
                  end
                  hcmt_pkg::PH_COMMA: begin
                     has_color_in = 1'b1;
                     if (hv[4]) begin
                        color_acc_in = {28'd0, hv[3:0]};
                        phase_in = (text_byte == hcmt_pkg::CHAR_ZERO) ? hcmt_pkg::PH_ZERO
                                                                      : hcmt_pkg::PH_HEX;
                     end else begin
                        phase_in = hcmt_pkg::PH_DONE;
                     end
                  end
                  hcmt_pkg::PH_ZERO: begin
                     if ((text_byte == hcmt_pkg::CHAR_LOWER_X)
                         || (text_byte == hcmt_pkg::CHAR_UPPER_X)) begin
                        phase_in = hcmt_pkg::PH_HEX;
                     end else if (hv[4]) begin
                        color_acc_in = {color_acc_ff[27:0], hv[3:0]};
                        phase_in     = hcmt_pkg::PH_HEX;
                     end else begin
                        phase_in = hcmt_pkg::PH_DONE;
                     end
                  end
                  hcmt_pkg::PH_HEX: begin
                     if (hv[4]) begin
                        color_acc_in = {color_acc_ff[27:0], hv[3:0]};
                     end else begin
                        phase_in = hcmt_pkg::PH_DONE;
                     end
                  end
                  default: ;
               endcase
            end

            // Whitespace or end of file closes an open token.
            if ((hcmt_pkg::is_space(text_byte) || end_of_file)
                && (phase_in != hcmt_pkg::PH_IDLE)) begin
               if (col_ext < width_lim) begin
                  point_res.kind   = hcmt_pkg::KIND_POINT;
                  point_res.column = col_ext[9:0];
                  point_res.row    = row_ext[9:0];
                  point_res.height = negative_in ? (32'd0 - height_acc_in) : height_acc_in;
                  point_res.color  = has_color_in ? color_acc_in : {8'd0, default_color_ff};
                  point_res.error  = hcmt_pkg::ERR_OK;
                  point_res.last   = !end_of_file;
                  push.valid_a     = 1'b1;
                  push.data_a      = point_res;
                  column_count_in  = CNT_W'(col_ext + CMP_W'(1));
               end
               phase_in = hcmt_pkg::PH_IDLE;
            end

            if (text_byte == hcmt_pkg::CHAR_NEWLINE) begin
               row_index_in    = CNT_W'(row_ext + CMP_W'(1));
               row_open_in     = 1'b0;
               column_count_in = '0;
            end

            if (end_of_file) begin
               lines = {1'b0, CMP_W'(row_index_in)} + {{CMP_W{1'b0}}, row_open_in};
               status_res.error = (lines != {1'b0, count_lim}) ? hcmt_pkg::ERR_TOO_FEW
                                                               : hcmt_pkg::ERR_OK;
               if (push.valid_a) begin
                  push.valid_b = 1'b1;
                  push.data_b  = status_res;
               end else begin
                  push.valid_a = 1'b1;
                  push.data_a  = status_res;
               end
               do_clear = 1'b1;
            end
         end
      end

      if (do_clear) begin
         phase_in        = hcmt_pkg::PH_IDLE;
         column_count_in = '0;
         row_index_in    = '0;
         height_acc_in   = '0;
         color_acc_in    = '0;
         negative_in     = 1'b0;
         has_color_in    = 1'b0;
         row_open_in     = 1'b0;
         halted_in       = 1'b0;
      end
   end

   assign status.halted   = halted_ff;
   assign status.row_open = row_open_ff;

endmodule

// ----- rtl/hcmt_out_fifo.sv -----
// Result queue of the tokenizer: takes up to two results a cycle, gives one.
// Depends on hcmt_pkg.
module hcmt_out_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  hcmt_pkg::push_type        push,
   input  logic                      pop,
   output logic                      out_valid,
   output hcmt_pkg::result_type      out_data,
   output hcmt_pkg::fifo_status_type status
);

   localparam int DEPTH = hcmt_pkg::FIFO_DEPTH;
   localparam int PTR_W = hcmt_pkg::FIFO_PTR_W;
   localparam int CNT_W = hcmt_pkg::FIFO_CNT_W;

   hcmt_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] push_n;
   logic             do_pop;

   assign push_n    = CNT_W'(push.valid_a) + CNT_W'(push.valid_b);
   assign out_valid = (count_ff != '0);
   assign do_pop    = pop && out_valid;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(push_n));
   assign rd_ptr_in = PTR_W'(rd_ptr_ff + PTR_W'(do_pop));
   assign count_in  = CNT_W'(count_ff + push_n - CNT_W'(do_pop));

   // Room is reserved for the worst case of two results per word.
   assign status.count    = count_ff;
   assign status.has_room = (count_ff <= CNT_W'(DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         entry_ff[wr_ptr_ff] <= push.data_a;
      end
      if (push.valid_b) begin
         entry_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= push.data_b;
      end
   end

endmodule

// ----- rtl/height_color_map_tokenizer_unit.sv -----
// Top level of the height color map tokenizer: text words in, point and status words out.
// Depends on hcmt_pkg, hcmt_if, hcmt_core, hcmt_out_fifo and the assertion macro header.

// The block reads map text one byte word per cycle and turns each whitespace separated
// token (a signed decimal height, optionally a comma and a hex color with an optional
// 0x prefix) into a point word carrying column, row, height and color. Tokens past
// row_width in a row are dropped, tokens without a color take default_color. A line that
// would open past row_count gives one status word with error 1, after which bytes are
// ignored up to and including end of file; otherwise the end-of-file byte gives a status
// word, error 2 when too few lines were seen. End of file returns the block to its
// start state with registers kept. The results of an accepted text word, at most two, are
// written into a four-entry result queue in the cycle it is taken; a new word is taken in
// every cycle while that queue holds at most two words, so a steady stream goes one word
// per cycle unless the result side stalls or two-result words fill the queue. Results
// leave one per cycle while the result side is ready. Configuration must be written only
// while the block is idle; the block does not enforce it. No clearing pass follows reset.
`include "height_color_map_tokenizer_unit_defines.svh"

module height_color_map_tokenizer_unit #(
   parameter int MAX_DIM = 1024
) (
   input  logic        clock,
   input  logic        reset,
   hcmt_req_if.sink    req_ch,
   hcmt_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   hcmt_pkg::push_type        push;
   hcmt_pkg::core_status_type core_status;
   hcmt_pkg::fifo_status_type fifo_status;
   hcmt_pkg::result_type      head;
   logic                      req_fire;
   logic                      head_valid;

   assign req_ch.ready = fifo_status.has_room;
   assign req_fire     = req_ch.valid && fifo_status.has_room;

   // Tokenizer state and register file; decides the results of each accepted word.
   hcmt_core #(
      .MAX_DIM (MAX_DIM)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_fire),
      .text_byte        (req_ch.text_byte),
      .end_of_file      (req_ch.end_of_file),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .status           (core_status)
   );

   // Result queue that parts the text side from the result side.
   hcmt_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ch.ready),
      .out_valid (head_valid),
      .out_data  (head),
      .status    (fifo_status)
   );

   assign rsp_ch.valid  = head_valid;
   assign rsp_ch.kind   = head.kind;
   assign rsp_ch.column = head.column;
   assign rsp_ch.row    = head.row;
   assign rsp_ch.height = head.height;
   assign rsp_ch.color  = head.color;
   assign rsp_ch.error  = head.error;
   assign rsp_ch.last   = head.last;

   // While halted, accepted words produce nothing.
   `HCMT_ASSERT_SAME(a_halted_silent, clock, reset, req_fire && core_status.halted,
      !push.valid_a && !push.valid_b, "halted tokenizer produced a result")

   // End of file outside the halted state always ends with a status word.
   `HCMT_ASSERT_SAME(a_eof_status, clock, reset,
      req_fire && req_ch.end_of_file && !core_status.halted,
      push.valid_a && (push.valid_b ? (push.data_b.kind == hcmt_pkg::KIND_STATUS)
                                    : (push.data_a.kind == hcmt_pkg::KIND_STATUS)),
      "end of file without a closing status word")

   // End of file returns the tokenizer to its start state.
   `HCMT_ASSERT_NEXT(a_eof_clears, clock, reset, req_fire && req_ch.end_of_file,
      !core_status.halted && !core_status.row_open, "state not cleared after end of file")

   // Results are pushed only while the queue has room for two more.
   `HCMT_ASSERT_SAME(a_fifo_bound, clock, reset, push.valid_a || push.valid_b,
      fifo_status.count <= hcmt_pkg::FIFO_CNT_W'(hcmt_pkg::FIFO_DEPTH - 2),
      "result pushed into a queue without room")

endmodule

// ----- bench/hcmt_tb_pkg.sv -----
// Scoreboard of the height color map tokenizer bench: predicts point and status words.
// Depends on hcmt_pkg for the result word layout, character codes and phase encoding.
`timescale 1ns / 100ps

package hcmt_tb_pkg;
   import hcmt_pkg::*;

   localparam int MAP_MAX_DIM = 1024;

   class token_point_scoreboard;
      // Register copies.
      logic [10:0] row_width;
      logic [10:0] row_count;
      logic [23:0] default_color;

      // Tokenizer state.
      phase_type   phase;
      logic [10:0] column_count;
      logic [10:0] row_index;
      logic [31:0] height_acc;
      logic        negative;
      logic [31:0] color_acc;
      logic        has_color;
      logic        row_open;
      logic        halted;

      result_type  word_results[$];
      result_type  awaited_words[$];
      int unsigned failures;
      int unsigned words_used;

      function new();
         row_width     = ROW_WIDTH_RESET;
         row_count     = ROW_COUNT_RESET;
         default_color = DEFAULT_COLOR_RESET;
         failures      = 0;
         words_used    = 0;
         restart_file();
      endfunction

      function void restart_file();
         phase        = PH_IDLE;
         column_count = '0;
         row_index    = '0;
         height_acc   = '0;
         negative     = 1'b0;
         color_acc    = '0;
         has_color    = 1'b0;
         row_open     = 1'b0;
         halted       = 1'b0;
      endfunction

      function void configure(logic [1:0] index, logic [23:0] value);
         case (index)
            CSR_ROW_WIDTH:     row_width = value[10:0];
            CSR_ROW_COUNT:     row_count = value[10:0];
            CSR_DEFAULT_COLOR: default_color = value;
            default: ;
         endcase
      endfunction

      function int outstanding();
         return awaited_words.size();
      endfunction

      function logic [10:0] capped(logic [10:0] v);
         return (v > MAP_MAX_DIM) ? 11'(MAP_MAX_DIM) : v;
      endfunction

      function bit is_blank(logic [7:0] b);
         return b inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
      endfunction

      // Nibble value of a hex digit of either case, or -1.
      function int nibble_of(logic [7:0] b);
         if (b inside {[CHAR_ZERO:CHAR_NINE]}) return int'(b - CHAR_ZERO);
         if (b inside {[8'h61:8'h66]}) return int'(b - 8'h61) + 10;
         if (b inside {[8'h41:8'h46]}) return int'(b - 8'h41) + 10;
         return -1;
      endfunction

      function result_type status_word(logic [1:0] code);
         result_type r;
         r       = '0;
         r.kind  = KIND_STATUS;
         r.error = code;
         return r;
      endfunction

      function void close_token();
         result_type r;
         if (phase != PH_IDLE) begin
            if (column_count < capped(row_width)) begin
               r        = '0;
               r.kind   = KIND_POINT;
               r.column = column_count[9:0];
               r.row    = row_index[9:0];
               r.height = negative ? (32'd0 - height_acc) : height_acc;
               r.color  = has_color ? color_acc : {8'h00, default_color};
               r.error  = ERR_OK;
               word_results.push_back(r);
               column_count++;
            end
            phase = PH_IDLE;
         end
      endfunction

      function void take_char(logic [7:0] b);
         int nib;
         bit dec;
         nib = nibble_of(b);
         dec = b inside {[CHAR_ZERO:CHAR_NINE]};
         case (phase)
            PH_IDLE: begin
               height_acc = '0;
               color_acc  = '0;
               has_color  = 1'b0;
               negative   = (b == CHAR_MINUS);
               if (b == CHAR_MINUS || b == CHAR_PLUS) begin
                  phase = PH_HEIGHT;
               end else if (dec) begin
                  height_acc = 32'(b - CHAR_ZERO);
                  phase = PH_HEIGHT;
               end else if (b == CHAR_COMMA) begin
                  phase = PH_COMMA;
               end else begin
                  phase = PH_SKIP;
               end
            end
            PH_HEIGHT: begin
               if (dec) height_acc = height_acc * 32'd10 + 32'(b - CHAR_ZERO);
               else phase = (b == CHAR_COMMA) ? PH_COMMA : PH_SKIP;
            end
            PH_SKIP: begin
               if (b == CHAR_COMMA) phase = PH_COMMA;
            end
            PH_COMMA: begin
               has_color = 1'b1;
               if (nib >= 0) begin
                  color_acc = 32'(nib);
                  phase = (b == CHAR_ZERO) ? PH_ZERO : PH_HEX;
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_ZERO: begin
               if (b == CHAR_LOWER_X || b == CHAR_UPPER_X) begin
                  phase = PH_HEX;
               end else if (nib >= 0) begin
                  color_acc = {color_acc[27:0], 4'(nib)};
                  phase = PH_HEX;
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_HEX: begin
               if (nib >= 0) color_acc = {color_acc[27:0], 4'(nib)};
               else phase = PH_DONE;
            end
            default: ;
         endcase
      endfunction

      // Called for every text word accepted by the block.
      function void note_text_word(logic [7:0] b, logic eof);
         int unsigned lines;
         if (halted) begin
            if (eof) restart_file();
            return;
         end
         words_used++;
         word_results.delete();
         if (!row_open && row_index >= capped(row_count)) begin
            word_results.push_back(status_word(ERR_TOO_MANY));
            halted = 1'b1;
            if (eof) restart_file();
         end else begin
            row_open = 1'b1;
            if (is_blank(b)) begin
               close_token();
               if (b == CHAR_NEWLINE) begin
                  row_index++;
                  row_open     = 1'b0;
                  column_count = '0;
               end
            end else begin
               take_char(b);
            end
            if (eof) begin
               close_token();
               lines = 32'(row_index) + 32'(row_open);
               word_results.push_back(status_word(
                  (lines != 32'(capped(row_count))) ? ERR_TOO_FEW : ERR_OK));
               restart_file();
            end
         end
         if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
         foreach (word_results[i]) awaited_words.push_back(word_results[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Called for every result word accepted from the block.
      function void check_result_word(result_type got);
         result_type want;
         if (awaited_words.size() == 0) begin
            failures++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            return;
         end
         want = awaited_words.pop_front();
         compare_field("kind", 32'(want.kind), 32'(got.kind));
         compare_field("column", 32'(want.column), 32'(got.column));
         compare_field("row", 32'(want.row), 32'(got.row));
         compare_field("height", want.height, got.height);
         compare_field("color", want.color, got.color);
         compare_field("error", 32'(want.error), 32'(got.error));
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

endpackage

// ----- bench/height_color_map_tokenizer_unit_tb.sv -----
// Top of the height color map tokenizer bench: clock, reset, text and result drivers.
// Depends on hcmt_pkg, hcmt_if, hcmt_tb_pkg and the height_color_map_tokenizer_unit RTL.
`timescale 1ns / 100ps

module height_color_map_tokenizer_unit_tb;
   import hcmt_pkg::*;
   import hcmt_tb_pkg::*;

   localparam int RANDOM_WORDS   = 1950;
   localparam int PHASE_WORDS    = 160;
   localparam int HOLD_CYCLES    = 200;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [23:0] csr_write_data;

   hcmt_req_if req_ch();
   hcmt_rsp_if rsp_ch();

   height_color_map_tokenizer_unit #(
      .MAX_DIM(MAP_MAX_DIM)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   token_point_scoreboard sb = new();

   // When steady is set neither side inserts idle cycles. The stimulus process asks for a
   // long result-side hold-off by bumping holds_ordered; the receiver serves it.
   bit          steady = 1'b0;
   int          holds_ordered = 0;
   int          holds_served = 0;
   int          quiet_cycles = 0;
   logic [7:0]  file_text[$];

   always #5 clock = ~clock;

   // Every handshake is observed here, at the rising edge, before any driver's
   // nonblocking updates land. The text word is handed to the predictor first so that
   // its results are queued before any result word of the same edge is checked.
   always @(posedge clock) begin
      result_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_text_word(req_ch.text_byte, req_ch.end_of_file);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind   = rsp_ch.kind;
            seen.column = rsp_ch.column;
            seen.row    = rsp_ch.row;
            seen.height = rsp_ch.height;
            seen.color  = rsp_ch.color;
            seen.error  = rsp_ch.error;
            seen.last   = rsp_ch.last;
            sb.check_result_word(seen);
         end
      end
   end

   // Watchdog: the run is stuck when no word moves on either side for too long. The
   // limit covers the long result hold-off plus the random gaps around it.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // Result side. It stalls at random with a chance of 17 percent, never while steady
   // is set, and on request holds ready low for a long stretch so that the block's result
   // queue fills and it has to stall the text side.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_ordered) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= 17);
      end
   end

   // Offers one text word, after a random number of idle cycles, and returns at the
   // edge where it is taken.
   task automatic send_word(input logic [7:0] b, input logic eof);
      while (!steady && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_byte   <= b;
      req_ch.end_of_file <= eof;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Sends the prepared file; its last byte carries the end-of-file flag.
   task automatic send_file();
      foreach (file_text[i]) send_word(file_text[i], i == file_text.size() - 1);
   endtask

   // Waits until every awaited result has come back, then lets the block settle.
   // The first edge makes sure the last accepted word has reached the predictor.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges with the enable held high.
   task automatic program_registers(input int width, input int count, input logic [23:0] color);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ROW_WIDTH;
      csr_write_data   <= 24'(width);
      @(posedge clock);
      csr_index        <= CSR_ROW_COUNT;
      csr_write_data   <= 24'(count);
      @(posedge clock);
      csr_index        <= CSR_DEFAULT_COLOR;
      csr_write_data   <= color;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.configure(CSR_ROW_WIDTH, 24'(width));
      sb.configure(CSR_ROW_COUNT, 24'(count));
      sb.configure(CSR_DEFAULT_COLOR, color);
   endtask

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
   endfunction

   // One whitespace separator: mostly a space, otherwise any of tab through
   // carriage return, which may itself be a newline.
   function automatic void append_blank();
      if ($urandom_range(3) != 0) file_text.push_back(CHAR_SPACE);
      else file_text.push_back(8'($urandom_range(CHAR_CR, CHAR_TAB)));
   endfunction

   // One token. Most are well formed: optional sign, decimal digits (sometimes enough
   // to wrap 32 bits), optional junk, optional comma and hex color with or without a
   // 0x prefix. A few are raw noise bytes over the full byte range.
   function automatic void append_token();
      string digs = "0123456789";
      string hexs = "0123456789abcdefABCDEF";
      string junk = "q.#Z_g";
      int    n;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(3, 1)) file_text.push_back(8'($urandom_range(255)));
         return;
      end
      case ($urandom_range(3))
         0: file_text.push_back(CHAR_MINUS);
         1: file_text.push_back(CHAR_PLUS);
         default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4);
      repeat (n) file_text.push_back(digs[$urandom_range(9)]);
      if ($urandom_range(9) == 0) file_text.push_back(junk[$urandom_range(5)]);
      if ($urandom_range(99) < 60) begin
         file_text.push_back(CHAR_COMMA);
         case ($urandom_range(4))
            0: begin
               file_text.push_back(CHAR_ZERO);
               file_text.push_back(CHAR_LOWER_X);
            end
            1: begin
               file_text.push_back(CHAR_ZERO);
               file_text.push_back(CHAR_UPPER_X);
            end
            2: file_text.push_back(CHAR_ZERO);
            default: ;
         endcase
         n = ($urandom_range(9) == 0) ? $urandom_range(10, 9) : $urandom_range(6);
         repeat (n) file_text.push_back(hexs[$urandom_range(21)]);
         if ($urandom_range(7) == 0) file_text.push_back(junk[$urandom_range(5)]);
         if ($urandom_range(15) == 0) file_text.push_back(CHAR_COMMA);
      end
   endfunction

   // Builds a file sized around the current settings: with few rows allowed the line
   // count ranges from none to one too many, and rows carry up to two tokens more
   // than are kept. The last line may lack its newline and end inside a token.
   function automatic void build_file(input int width, input int count);
      int  lines;
      int  tokens;
      bit  cut_short;
      file_text.delete();
      lines = (count <= 8) ? $urandom_range(count + 1) : $urandom_range(4, 1);
      for (int l = 0; l < lines; l++) begin
         cut_short = (l == lines - 1) && ($urandom_range(1) == 0);
         tokens = (width <= 8) ? $urandom_range(width + 2) : $urandom_range(6);
         if ($urandom_range(7) == 0) append_blank();
         for (int t = 0; t < tokens; t++) begin
            append_token();
            if (!(cut_short && t == tokens - 1)) append_blank();
         end
         if (!cut_short) file_text.push_back(CHAR_NEWLINE);
      end
      if (file_text.size() == 0) file_text.push_back(8'($urandom_range(255)));
   endfunction

   initial begin
      int phase_no;
      int phase_start;
      int width;
      int count;
      logic [23:0] color;

      req_ch.valid       <= 1'b0;
      req_ch.text_byte   <= '0;
      req_ch.end_of_file <= 1'b0;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_ROW_WIDTH;
      csr_write_data     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed file under the reset register values: signed heights, a capital 0X
      // prefix, a comma with nothing after it (default color), junk after a height,
      // a zero followed by a hex digit, the extreme byte values, and end of file
      // inside a noise token with far fewer rows than required.
      file_text.delete();
      append_text("+5,0Xf -7, 3q,0aZ\n");
      file_text.push_back(8'hFF);
      file_text.push_back(8'h00);
      send_file();
      drain();

      // Smallest row width and row count: the second token of the row is dropped,
      // the second line raises too many rows, and the rest of the file, its
      // end-of-file byte included, is ignored.
      program_registers(1, 1, 24'h000000);
      file_text.delete();
      append_text("1 2\n3\nx");
      send_file();
      drain();

      // Random phases, each under its own settings, the extremes among them. The last
      // phase starts half a phase short of the word budget so the total lands near it.
      phase_no = 0;
      while (sb.words_used + PHASE_WORDS / 2 < RANDOM_WORDS) begin
         case (phase_no % 6)
            0: begin
               width = 1;
               count = 1;
               color = 24'h000000;
            end
            1: begin
               width = MAP_MAX_DIM;
               count = MAP_MAX_DIM;
               color = 24'hFFFFFF;
            end
            2: begin
               width = 3;
               count = 2;
               color = 24'($urandom);
            end
            3: begin
               width = $urandom_range(6, 1);
               count = $urandom_range(6, 1);
               color = 24'($urandom);
            end
            4: begin
               width = 2;
               count = 5;
               color = 24'($urandom);
            end
            default: begin
               width = MAP_MAX_DIM;
               count = $urandom_range(4, 1);
               color = 24'($urandom);
            end
         endcase
         program_registers(width, count, color);
         // One phase runs without any idling; another starts with the long hold-off
         // while text keeps coming.
         steady = (phase_no == 4);
         if (phase_no == 2) holds_ordered++;
         phase_start = sb.words_used;
         while (sb.words_used - phase_start < PHASE_WORDS) begin
            build_file(width, count);
            send_file();
         end
         drain();
         phase_no++;
      end
      steady = 1'b0;

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- height_color_map_tokenizer_unit.f -----
+incdir+rtl
rtl/hcmt_pkg.sv
rtl/hcmt_if.sv
rtl/hcmt_core.sv
rtl/hcmt_out_fifo.sv
rtl/height_color_map_tokenizer_unit.sv
bench/hcmt_tb_pkg.sv
bench/height_color_map_tokenizer_unit_tb.sv
